@@ hw/rtl/apq_pkg.sv @@
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants for the array priority queue unit: field widths,
// result codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package apq_pkg;

    localparam int DATA_W   = 32;
    localparam int PRI_W    = 8;
    localparam int STATUS_W = 2;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        RES_DONE  = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } res_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_SHIFT,
        S_SHIFT_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [PRI_W-1:0]  pri;
        logic [DATA_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic scan_issue;
        logic scan_cmp;
        logic shift_start;
        logic shift_issue;
        logic shift_wr;
        logic count_dec;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic deq_start;
        logic scan_last;
        logic shift_more;
    } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/apq_if.sv @@
// ----------------------------------------------------------------------------
// apq_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface apq_req_if;
    logic                valid;
    logic                ready;
    logic                action;
    logic signed [31:0]  data_value;
    logic [7:0]          priority_req;

    modport source (output valid, output action, output data_value,
                    output priority_req, input ready);
    modport sink   (input valid, input action, input data_value,
                    input priority_req, output ready);
endinterface

interface apq_rsp_if;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic                out_valid;
    logic signed [31:0]  out_value;

    modport source (output valid, output status, output out_valid,
                    output out_value, input ready);
    modport sink   (input valid, input status, input out_valid,
                    input out_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/apq_ctrl.sv @@
// ----------------------------------------------------------------------------
// apq_ctrl
// Controller state machine: handshakes, scan and shift sequencing,
// response word hold.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    input  wire apq_pkg::stat_t stat,
    output apq_pkg::cmd_t      cmd
);
    import apq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~rsp_ready;
        cmd            = '0;
        req_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.deq_start ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                cmd.scan_cmp   = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                cmd.scan_cmp    = 1'b1;
                cmd.shift_start = 1'b1;
                state_next      = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (stat.shift_more)
                begin
                    cmd.shift_issue = 1'b1;
                end
                else
                begin
                    state_next = S_SHIFT_END;
                end
            end
            S_SHIFT_END:
            begin
                cmd.shift_wr  = 1'b1;
                cmd.count_dec = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/apq_datapath.sv @@
// ----------------------------------------------------------------------------
// apq_datapath
// Entry memory, fill count, minimum search registers, shift pipeline
// and response word register.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_datapath #(
    parameter int DEPTH = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire apq_pkg::cmd_t               cmd,
    output apq_pkg::stat_t                   stat,
    input  wire logic                        action,
    input  wire logic signed [31:0]          data_value,
    input  wire logic [7:0]                  priority_req,
    output logic [1:0]                       status,
    output logic                             out_valid,
    output logic signed [31:0]               out_value
);
    import apq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t mem [DEPTH];

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     idx_next;
    logic              rd_pend_reg;
    logic [AW-1:0]     rd_idx_reg;
    entry_t            rd_data_reg;
    logic [AW-1:0]     best_idx_reg;
    logic [AW-1:0]     best_idx_next;
    logic [PRI_W-1:0]  best_pri_reg;
    logic [DATA_W-1:0] best_val_reg;
    logic              take;
    logic              full;
    logic              enq_wr;
    logic              sh_wr;
    res_status_t       res_status_reg;
    logic              res_valid_reg;
    logic [1:0]        status_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;

    assign full   = (count_reg == CW'(DEPTH));
    assign enq_wr = cmd.accept && (action == ACT_ENQ) && !full;
    assign sh_wr  = cmd.shift_wr && rd_pend_reg;
    assign take   = cmd.scan_cmp && rd_pend_reg &&
                    ((rd_idx_reg == '0) || (rd_data_reg.pri < best_pri_reg));

    assign best_idx_next = take ? rd_idx_reg : best_idx_reg;

    assign stat.deq_start  = (action == ACT_DEQ) && (count_reg != '0);
    assign stat.scan_last  = ((idx_reg + CW'(1)) == count_reg);
    assign stat.shift_more = (idx_reg < count_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.shift_start)
        begin
            idx_next = CW'(best_idx_next) + CW'(1);
        end
        else if (cmd.scan_issue || cmd.shift_issue)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (enq_wr)
        begin
            mem[count_reg[AW-1:0]] <= '{pri: priority_req, value: data_value};
        end
        else if (sh_wr)
        begin
            mem[rd_idx_reg - AW'(1)] <= rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[idx_reg[AW-1:0]];
        rd_idx_reg  <= idx_reg[AW-1:0];
        if (take)
        begin
            best_pri_reg <= rd_data_reg.pri;
            best_val_reg <= rd_data_reg.value;
        end
        if (cmd.load_out)
        begin
            status_reg    <= res_status_reg;
            out_value_reg <= res_valid_reg ? best_val_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            best_idx_reg   <= '0;
            res_status_reg <= RES_DONE;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            rd_pend_reg  <= cmd.scan_issue | cmd.shift_issue;
            best_idx_reg <= best_idx_next;
            if (enq_wr)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.accept)
            begin
                res_valid_reg <= stat.deq_start;
                if (action == ACT_ENQ)
                begin
                    res_status_reg <= full ? RES_FULL : RES_DONE;
                end
                else
                begin
                    res_status_reg <= stat.deq_start ? RES_DONE : RES_EMPTY;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= res_valid_reg;
            end
        end
    end

    assign status    = status_reg;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_shift_target: assert property (@(posedge clk) disable iff (!rst_n)
        sh_wr |-> (rd_idx_reg != '0))
        else $error("shift write below head");

    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_dec |-> (count_reg != '0))
        else $error("count decrement on empty queue");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.load_out) && !out_valid_reg |-> (out_value_reg == '0))
        else $error("nonzero value without dequeue");

endmodule

`default_nettype wire

@@ hw/rtl/array_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// array_priority_queue_unit
// Array-backed priority queue: enqueue at tail, dequeue the smallest
// priority number (earliest entry on a tie) and close the gap.
// ----------------------------------------------------------------------------
// enqueue or empty/full result: accept, then the done state loads the response word
// dequeue: scan of all n entries for the winner, then shift of the entries behind it,
// one entry per cycle through the single read port for the scan and again for the shift
// next word is accepted once the response is registered, even while it waits
// reset: asynchronous, clears the entry count and the handshake state
`default_nettype none

module array_priority_queue_unit #(
    parameter int DEPTH = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    apq_req_if.sink   req,
    apq_rsp_if.source rsp
);
    import apq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    apq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    apq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (req.action),
        .data_value   (req.data_value),
        .priority_req (req.priority_req),
        .status       (rsp.status),
        .out_valid    (rsp.out_valid),
        .out_value    (rsp.out_value)
    );

endmodule

`default_nettype wire
